// File: design/svf_pkg.sv
// Shared constants for the state-variable filter: register indexes, output
// mode codes and reset values.  No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svf_pkg;

	// Default number of fractional bits in all fixed-point quantities.
	localparam int FRAC_BITS_DEF = 16;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_FREQ_COEF   = 2'd0;
	localparam logic [1:0] REG_RESONANCE   = 2'd1;
	localparam logic [1:0] REG_OUTPUT_MODE = 2'd2;

	// Output mode codes; every other code selects the lowpass output.
	localparam logic [1:0] MODE_LOWPASS  = 2'd0;
	localparam logic [1:0] MODE_HIGHPASS = 2'd1;
	localparam logic [1:0] MODE_BANDPASS = 2'd2;

	// Frequency coefficient after reset, given at 16 fractional bits.
	localparam longint FREQ_RESET_Q16 = 11498;
	localparam int     FREQ_RESET_FRAC = 16;

endpackage

`default_nettype wire

// File: design/state_variable_filter.sv
// Top level of the Chamberlin state-variable filter: configuration registers,
// sequencer and datapath around one shared multiplier.  Uses svf_pkg and svf_mul.
`timescale 1ns / 1ps
`default_nettype none

// Chamberlin state-variable filter on signed fixed point with FRAC_BITS
// fractional bits (Q3.16 by default).
//
// Samples arrive on the s_ channel and one filtered sample leaves on the m_
// channel for every sample taken.  Software sets the frequency coefficient,
// the resonance and the output mode through the write port (cfg_wen,
// cfg_index, cfg_data) while the filter is idle; writes to an unused index
// are ignored.
//
// Each sample runs four multiplications through a single registered
// multiplier: the damping from the resonance, then f*band, q*band and
// f*high, each of which waits for the previous sum.  The sequencer passes
// through its six working states from ST_DAMP to ST_WRITE, leaving
// ST_WRITE only once the output register is free, and the filter takes no
// new sample until the last result is written; s_tready is high only
// while the sequencer is idle.
//
// Reset clears both integrators, sets the frequency coefficient to its
// default (about 0.175), the resonance to zero and the mode to lowpass.
// If the receiver stalls, the result stays in the output register.  The
// next sample is still taken and computed, but its result and the
// integrator update wait until that beat has been taken, and no further
// sample is accepted meanwhile.
module state_variable_filter #(
	parameter int FRAC_BITS = svf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_wen,
	input  wire logic [1:0]                          cfg_index,
	input  wire logic [FRAC_BITS:0]                  cfg_data,
	// sample input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// bits from lowest: sample_in (FRAC_BITS+4, signed), then zero fill
	input  wire logic [((FRAC_BITS+4+7)/8)*8-1:0]    s_tdata,
	// sample output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// bits from lowest: sample_out (FRAC_BITS+3, signed), then zero fill
	output logic [((FRAC_BITS+3+7)/8)*8-1:0]         m_tdata
);
	import svf_pkg::*;

	localparam int CFG_W  = FRAC_BITS + 1;
	localparam int IN_W   = FRAC_BITS + 4;
	localparam int ST_W   = FRAC_BITS + 3;
	localparam int W      = FRAC_BITS + 5;
	localparam int P_W    = CFG_W + W + 1;
	localparam int OUTD_W = ((FRAC_BITS + 3 + 7) / 8) * 8;

	localparam longint ONE_L   = 64'sd1 <<< FRAC_BITS;
	localparam longint K090_L  = (9 * ONE_L) / 10;
	localparam longint K005_L  = (5 * ONE_L) / 100;
	localparam longint LIM_L   = 2 * ONE_L;
	localparam longint FRST_L  = (FREQ_RESET_Q16 <<< FRAC_BITS) >>> FREQ_RESET_FRAC;

	localparam logic [CFG_W-1:0]  ONE_C   = CFG_W'(ONE_L);
	localparam logic [CFG_W-1:0]  K005_C  = CFG_W'(K005_L);
	localparam logic [CFG_W-1:0]  FRST_C  = CFG_W'(FRST_L);
	localparam logic signed [W-1:0] K090_W = W'(K090_L);
	localparam logic signed [W-1:0] ONE_W  = W'(ONE_L);
	localparam logic signed [W-1:0] K005_W = W'(K005_L);
	localparam logic signed [W-1:0] LIM_W  = W'(LIM_L);
	localparam logic signed [W-1:0] NLIM_W = W'(-LIM_L);

	typedef enum logic [3:0] {
		ST_IDLE,   // waiting for a sample
		ST_DAMP,   // damping product ready
		ST_LOW,    // f*band ready, q*band issued
		ST_HIGH,   // q*band ready
		ST_FHI,    // f*high issued
		ST_BAND,   // f*high ready
		ST_WRITE   // results ready, waiting for the output register
	} seq_state_t;

	seq_state_t state_q;

	// configuration
	logic [CFG_W-1:0] freq_q;
	logic [CFG_W-1:0] res_q;
	logic [1:0]       mode_q;

	// filter state and per-sample working registers
	logic signed [ST_W-1:0] low_q;
	logic signed [ST_W-1:0] band_q;
	logic signed [IN_W-1:0] x_q;
	logic [CFG_W-1:0]       damp_q;
	logic signed [W-1:0]    lo_q;
	logic signed [W-1:0]    hi_q;
	logic signed [W-1:0]    bd_q;

	logic                    out_valid_q;
	logic signed [ST_W-1:0]  out_q;

	// shared multiplier
	logic [CFG_W-1:0]       mul_a;
	logic signed [W-1:0]    mul_b;
	logic signed [P_W-1:0]  mul_p;
	logic signed [W-1:0]    prod;

	logic [CFG_W-1:0]       freq_clamp;
	logic [CFG_W-1:0]       res_clamp;
	logic signed [W-1:0]    low_w;
	logic signed [W-1:0]    band_w;
	logic signed [W-1:0]    x_w;
	logic signed [W-1:0]    damp_sum;
	logic signed [W-1:0]    lo_sum;
	logic signed [W-1:0]    hi_sum;
	logic signed [W-1:0]    bd_sum;
	logic signed [ST_W-1:0] lo_sat;
	logic signed [ST_W-1:0] hi_sat;
	logic signed [ST_W-1:0] bd_sat;
	logic                   out_free;

	function automatic logic signed [ST_W-1:0] sat2(input logic signed [W-1:0] v);
		logic signed [ST_W-1:0] r;
		if (v > LIM_W) begin
			r = LIM_W[ST_W-1:0];
		end else if (v < NLIM_W) begin
			r = NLIM_W[ST_W-1:0];
		end else begin
			r = v[ST_W-1:0];
		end
		return r;
	endfunction

	assign freq_clamp = (freq_q > ONE_C) ? ONE_C : freq_q;
	assign res_clamp  = (res_q > ONE_C) ? ONE_C : res_q;

	assign low_w  = {{(W-ST_W){low_q[ST_W-1]}}, low_q};
	assign band_w = {{(W-ST_W){band_q[ST_W-1]}}, band_q};
	assign x_w    = {{(W-IN_W){x_q[IN_W-1]}}, x_q};

	// Dropping the low fraction bits of a two's-complement product floors it.
	assign prod = mul_p[FRAC_BITS +: W];

	assign damp_sum = ONE_W - prod;
	assign lo_sum   = low_w + prod;
	assign hi_sum   = x_w - lo_q - prod;
	assign bd_sum   = band_w + prod;

	assign lo_sat = sat2(lo_q);
	assign hi_sat = sat2(hi_q);
	assign bd_sat = sat2(bd_q);

	assign out_free = !out_valid_q || m_tready;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = res_clamp;
		mul_b = K090_W;
		case (state_q)
			ST_DAMP: begin
				mul_a = freq_clamp;
				mul_b = band_w;
			end
			ST_LOW: begin
				mul_a = damp_q;
				mul_b = band_w;
			end
			ST_FHI: begin
				mul_a = freq_clamp;
				mul_b = hi_q;
			end
			default: begin
				mul_a = res_clamp;
				mul_b = K090_W;
			end
		endcase
	end

	svf_mul #(
		.A_W (CFG_W),
		.B_W (W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FRST_C;
			res_q  <= '0;
			mode_q <= MODE_LOWPASS;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_FREQ_COEF:   freq_q <= cfg_data;
				REG_RESONANCE:   res_q  <= cfg_data;
				REG_OUTPUT_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, integrators and output register.  The multiplier is
	// started with the damping product on the accepting beat; later states
	// consume each product and start the next once its operands are ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= '0;
			band_q      <= '0;
			x_q         <= '0;
			damp_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			bd_q        <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken
			// beat empties it.
			if (state_q == ST_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						x_q     <= s_tdata[IN_W-1:0];
						state_q <= ST_DAMP;
					end
				end
				ST_DAMP: begin
					damp_q  <= (damp_sum < K005_W) ? K005_C : damp_sum[CFG_W-1:0];
					state_q <= ST_LOW;
				end
				ST_LOW: begin
					lo_q    <= lo_sum;
					state_q <= ST_HIGH;
				end
				ST_HIGH: begin
					hi_q    <= hi_sum;
					state_q <= ST_FHI;
				end
				ST_FHI: begin
					state_q <= ST_BAND;
				end
				ST_BAND: begin
					bd_q    <= bd_sum;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (out_free) begin
						low_q  <= lo_sat;
						band_q <= bd_sat;
						case (mode_q)
							MODE_HIGHPASS: out_q <= hi_sat;
							MODE_BANDPASS: out_q <= bd_sat;
							default:       out_q <= lo_sat;
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUTD_W-ST_W){1'b0}}, out_q};

endmodule

`default_nettype wire

// File: design/svf_mul.sv
// Shared multiplier of the state-variable filter: unsigned coefficient times
// signed operand, product registered.  No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module svf_mul #(
	parameter int A_W = 17,
	parameter int B_W = 21
) (
	input  wire logic                     clk,
	input  wire logic [A_W-1:0]           a,
	input  wire logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W:0]       p
);

	logic signed [A_W:0] a_signed;

	assign a_signed = $signed({1'b0, a});

	always_ff @(posedge clk) begin
		p <= a_signed * b;
	end

endmodule

`default_nettype wire
